/* design/ppa_pkg.sv */
// Package for the pointer packet assembler: event layout, framing states and sizes.
// Used by every module of the block but ppa_ram; depends on nothing.
`default_nettype none

package ppa_pkg;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned EVENT_W     = 23;
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 24;
  localparam int unsigned TUSER_OUT_W = 2;

  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_IDX_W   = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WHEEL_ENABLED = '0;

  localparam logic [BYTE_W-1:0] SYNC_MASK     = 8'h08;
  localparam logic [BYTE_W-1:0] OVERFLOW_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] NIBBLE_MASK   = 8'h0F;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_TAKE = 1'b1;

  typedef enum logic [1:0] {
    POS_FIRST,
    POS_SECOND,
    POS_THIRD,
    POS_WHEEL
  } byte_pos_e;

  typedef struct packed {
    logic [3:0] delta_z;
    logic [7:0] delta_y;
    logic [7:0] delta_x;
    logic       middle_button;
    logic       right_button;
    logic       left_button;
  } event_t;

  typedef struct packed {
    logic   push;
    event_t evt;
  } push_req_t;

  typedef struct packed {
    logic hit;
    logic not_empty;
  } ring_status_t;

endpackage

`default_nettype wire

/* design/ppa_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module ppa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/ppa_framer.sv */
// Byte framer: assembles three- or four-byte packets and issues event pushes.
// Depends on ppa_pkg.
`default_nettype none

module ppa_framer
  import ppa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              byte_en_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic              wheel_enabled_i,
  output push_req_t              push_o
);

  byte_pos_e         pos_q, pos_d;
  logic [BYTE_W-1:0] first_q, second_q, third_q;
  logic              finish;
  logic [BYTE_W-1:0] y_byte;
  logic [3:0]        z_nib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_FIRST;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      third_q  <= '0;
    end else if (byte_en_i) begin
      if (pos_q == POS_FIRST) begin
        first_q <= byte_i;
      end
      if (pos_q == POS_SECOND) begin
        second_q <= byte_i;
      end
      if (pos_q == POS_THIRD) begin
        third_q <= byte_i;
      end
    end
  end

  always_comb begin
    pos_d  = pos_q;
    finish = 1'b0;
    y_byte = third_q;
    z_nib  = '0;
    unique case (pos_q)
      POS_FIRST: begin
        if (byte_en_i && ((byte_i & SYNC_MASK) != '0)) begin
          pos_d = POS_SECOND;
        end
      end
      POS_SECOND: begin
        if (byte_en_i) begin
          pos_d = POS_THIRD;
        end
      end
      POS_THIRD: begin
        y_byte = byte_i;
        if (byte_en_i) begin
          if (wheel_enabled_i) begin
            pos_d = POS_WHEEL;
          end else begin
            pos_d  = POS_FIRST;
            finish = 1'b1;
          end
        end
      end
      POS_WHEEL: begin
        if (wheel_enabled_i) begin
          z_nib = 4'(byte_i & NIBBLE_MASK);
        end
        if (byte_en_i) begin
          pos_d  = POS_FIRST;
          finish = 1'b1;
        end
      end
      default: begin
        pos_d = POS_FIRST;
      end
    endcase
  end

  always_comb begin
    push_o.push              = finish && ((first_q & OVERFLOW_MASK) == '0);
    push_o.evt.left_button   = first_q[0];
    push_o.evt.right_button  = first_q[1];
    push_o.evt.middle_button = first_q[2];
    push_o.evt.delta_x       = second_q;
    push_o.evt.delta_y       = y_byte;
    push_o.evt.delta_z       = z_nib;
  end

endmodule

`default_nettype wire

/* design/ppa_ring.sv */
// Event ring: read and write pointers around one event memory, push and pop.
// Depends on ppa_pkg and ppa_ram.
`default_nettype none

module ppa_ring
  import ppa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  push_req_t      push_i,
  input  wire logic      pop_i,
  output ring_status_t   status_o,
  output event_t         rdata_o
);

  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [PTR_W-1:0] wp_next, rp_next;
  logic             push_en, pop_en;
  logic [EVENT_W-1:0] ram_rdata;

  assign wp_next = (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;

  assign push_en = push_i.push && (wp_next != rp_q);
  assign pop_en  = pop_i && (rp_q != wp_q);

  assign wp_d = push_en ? wp_next : wp_q;
  assign rp_d = pop_en ? rp_next : rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      wp_q <= '0;
    end else begin
      rp_q <= rp_d;
      wp_q <= wp_d;
    end
  end

  ppa_ram #(
    .WIDTH(EVENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (push_en),
    .waddr_i(wp_q),
    .wdata_i(push_i.evt),
    .re_i   (pop_en),
    .raddr_i(rp_q),
    .rdata_o(ram_rdata)
  );

  assign rdata_o            = event_t'(ram_rdata);
  assign status_o.hit       = pop_en;
  assign status_o.not_empty = (rp_d != wp_d);

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_en |-> (rp_q != wp_q))
    else $error("Event memory read issued on an empty ring.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_en |=> (rp_q != wp_q))
    else $error("Ring empty after an accepted push.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rp_q <= PTR_W'(QUEUE_DEPTH - 1)) && (wp_q <= PTR_W'(QUEUE_DEPTH - 1)))
    else $error("Ring pointer outside the memory.");

endmodule

`default_nettype wire

/* design/pointer_packet_assembler_fifo.sv */
// Top level of the pointer packet assembler: streaming ports, register port, result pipeline.
// Depends on ppa_pkg, ppa_framer and ppa_ring.
// The block takes one word per clock cycle while the result stream does not stall, device
// bytes and event takes alike, and gives one result word for each from stage s2, after s1;
// s2 captures the registered event memory read. The memory needs no clearing after reset.
`default_nettype none

module pointer_packet_assembler_fifo
  import ppa_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic                   s_axis_tuser,   // [0] action
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [TDATA_OUT_W-1:0] m_axis_tdata,   // [0] left, [1] right, [2] middle,
                                                      // [10:3] delta_x, [18:11] delta_y,
                                                      // [22:19] delta_z, [23] zero
  output logic      [TUSER_OUT_W-1:0] m_axis_tuser,   // [0] event_valid, [1] queue_not_empty
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic         wheel_q;
  logic         accept, advance;
  logic         reg_hit;
  push_req_t    push_req;
  ring_status_t ring_status;
  event_t       ring_rdata;

  logic         s1_valid_q, s1_hit_q, s1_ne_q;
  logic         s2_valid_q, s2_hit_q, s2_ne_q;
  event_t       s2_evt_q;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_WHEEL_ENABLED);
  assign prdata  = reg_hit ? {{(APB_DATA_W-1){1'b0}}, wheel_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      wheel_q <= pwdata[0];
    end
  end

  assign advance       = !s2_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ppa_framer u_framer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_en_i      (accept && (s_axis_tuser == ACTION_BYTE)),
    .byte_i         (s_axis_tdata),
    .wheel_enabled_i(wheel_q),
    .push_o         (push_req)
  );

  ppa_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_req),
    .pop_i   (accept && (s_axis_tuser == ACTION_TAKE)),
    .status_o(ring_status),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hit_q <= ring_status.hit;
      s1_ne_q  <= ring_status.not_empty;
    end
    if (advance && s1_valid_q) begin
      s2_hit_q <= s1_hit_q;
      s2_ne_q  <= s1_ne_q;
      s2_evt_q <= s1_hit_q ? ring_rdata : '0;
    end
  end

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {1'b0, s2_evt_q};
  assign m_axis_tuser  = {s2_ne_q, s2_hit_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> s1_valid_q)
    else $error("Accepted word did not enter the result pipeline.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_hit_q && !advance) |=> (s1_valid_q && $stable(ring_rdata)))
    else $error("Pending read data changed while the result pipeline stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_hit_q) |-> (s2_evt_q == '0))
    else $error("Result without an event carries non-zero fields.");

endmodule

`default_nettype wire

/* tb/pointer_packet_assembler_fifo_tb.sv */
// Self-checking testbench for the pointer packet assembler: device bytes and event takes
// go in on the input stream, and every result word is checked against a built-in predictor.
// Depends on ppa_pkg and pointer_packet_assembler_fifo.
`timescale 1ns / 100ps

module pointer_packet_assembler_fifo_tb;
  import ppa_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic   valid;
    event_t evt;
    logic   not_empty;
  } pointer_result_t;

  class pointer_event_tracker;
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    logic wheel_on = 1'b0;
    byte_pos_e position = POS_FIRST;
    logic [7:0] head_byte = '0;
    logic [7:0] x_byte = '0;
    logic [7:0] y_byte = '0;
    event_t ring [QUEUE_DEPTH];
    int unsigned rd_idx = 0;
    int unsigned wr_idx = 0;
    pointer_result_t awaited_results [$];

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_WHEEL_ENABLED) begin
        wheel_on = value[0];
      end
    endfunction

    function void close_packet(logic [3:0] nibble);
      event_t ev;
      int unsigned nxt;
      if ((head_byte & OVERFLOW_MASK) != '0) begin
        return;
      end
      ev.left_button   = head_byte[0];
      ev.right_button  = head_byte[1];
      ev.middle_button = head_byte[2];
      ev.delta_x       = x_byte;
      ev.delta_y       = y_byte;
      ev.delta_z       = nibble;
      nxt = (wr_idx + 1) % QUEUE_DEPTH;
      if (nxt != rd_idx) begin
        ring[wr_idx] = ev;
        wr_idx = nxt;
      end
    endfunction

    function void note_word(logic act, logic [7:0] b);
      pointer_result_t res;
      logic [7:0] masked;
      res = '0;
      masked = b & NIBBLE_MASK;
      if (act == ACTION_BYTE) begin
        case (position)
          POS_FIRST: begin
            if ((b & SYNC_MASK) != '0) begin
              head_byte = b;
              position = POS_SECOND;
            end
          end
          POS_SECOND: begin
            x_byte = b;
            position = POS_THIRD;
          end
          POS_THIRD: begin
            y_byte = b;
            if (wheel_on) begin
              position = POS_WHEEL;
            end else begin
              position = POS_FIRST;
              close_packet(4'h0);
            end
          end
          default: begin
            position = POS_FIRST;
            close_packet(wheel_on ? masked[3:0] : 4'h0);
          end
        endcase
      end else if (rd_idx != wr_idx) begin
        res.valid = 1'b1;
        res.evt = ring[rd_idx];
        rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
      end
      res.not_empty = (rd_idx != wr_idx);
      awaited_results.push_back(res);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      if (errors < 60) begin
        $display("result %0d: %s is %0h, predicted %0h", results_seen, field, got, want);
      end
      errors++;
    endtask

    task check_result(logic [TDATA_OUT_W-1:0] tdata, logic [TUSER_OUT_W-1:0] tuser);
      pointer_result_t want;
      event_t got;
      got = tdata[EVENT_W-1:0];
      if (awaited_results.size() == 0) begin
        report("unexpected word", tdata, '0);
      end else begin
        want = awaited_results.pop_front();
        if (tuser[0] !== want.valid) report("event_valid", tuser[0], want.valid);
        if (got.left_button !== want.evt.left_button)
          report("left_button", got.left_button, want.evt.left_button);
        if (got.right_button !== want.evt.right_button)
          report("right_button", got.right_button, want.evt.right_button);
        if (got.middle_button !== want.evt.middle_button)
          report("middle_button", got.middle_button, want.evt.middle_button);
        if (got.delta_x !== want.evt.delta_x) report("delta_x", got.delta_x, want.evt.delta_x);
        if (got.delta_y !== want.evt.delta_y) report("delta_y", got.delta_y, want.evt.delta_y);
        if (got.delta_z !== want.evt.delta_z) report("delta_z", got.delta_z, want.evt.delta_z);
        if (tuser[1] !== want.not_empty) report("queue_not_empty", tuser[1], want.not_empty);
      end
      results_seen++;
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;    // [7:0] data_byte
  logic                   s_axis_tuser = 1'b0;  // [0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;         // [2:0] buttons, [10:3] x, [18:11] y, [22:19] z
  logic [TUSER_OUT_W-1:0] m_axis_tuser;         // [0] event_valid, [1] queue_not_empty
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  pointer_event_tracker tracker = new;
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_cycle = 0;
  bit          hold_req = 1'b0;

  pointer_packet_assembler_fifo DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata, m_axis_tuser);
    end
    rx_cycle++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_cycle % 3 != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("pointer_packet_assembler_fifo_tb: errors");
        $finish;
      end
    end
  end

  task automatic send_word(logic act, logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    tracker.note_word(act, b);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_packet(logic [7:0] head, logic [7:0] dx, logic [7:0] dy,
                             logic [7:0] wheel_byte);
    send_word(ACTION_BYTE, head);
    send_word(ACTION_BYTE, dx);
    send_word(ACTION_BYTE, dy);
    if (tracker.wheel_on) begin
      send_word(ACTION_BYTE, wheel_byte);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [REG_IDX_W-1:0] idx, logic value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom();
    word[0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.write_register(idx, word);
  endtask

  task automatic run_mix(int unsigned count, int unsigned take_pct, int unsigned noise_pct);
    int unsigned goal;
    int unsigned r;
    logic [7:0] head;
    goal = words_sent + count;
    while (words_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < noise_pct) begin
        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (r < noise_pct + take_pct) begin
        send_word(ACTION_TAKE, 8'($urandom_range(0, 255)));
      end else begin
        head = 8'($urandom_range(0, 255)) | SYNC_MASK;
        if ($urandom_range(0, 9) != 0) begin
          head = head & ~OVERFLOW_MASK;
        end
        send_packet(head, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Three-byte framing: empty take, lost sync, a good packet and both overflow drops.
    send_word(ACTION_TAKE, 8'hFF);
    send_word(ACTION_BYTE, 8'h00);
    send_packet(8'h0F, 8'h80, 8'h7F, 8'h00);
    send_packet(8'h48, 8'h01, 8'h02, 8'h00);
    send_packet(8'h88, 8'h03, 8'h04, 8'h00);
    send_word(ACTION_TAKE, 8'h00);
    settle();
    write_register(REG_WHEEL_ENABLED, 1'b1);
    write_register(REG_UNUSED, 1'b0);
    send_packet(8'h0C, 8'hFF, 8'h00, 8'hF7);
    send_packet(8'h08, 8'h7F, 8'h80, 8'h08);
    send_word(ACTION_TAKE, 8'h55);
    send_word(ACTION_TAKE, 8'hAA);

    // The wheel is switched off with three bytes of a wheel packet already held.
    send_word(ACTION_BYTE, 8'h09);
    send_word(ACTION_BYTE, 8'h05);
    send_word(ACTION_BYTE, 8'h06);
    settle();
    write_register(REG_WHEEL_ENABLED, 1'b0);
    send_word(ACTION_BYTE, 8'hAB);
    send_word(ACTION_TAKE, 8'h00);

    settle();
    write_register(REG_WHEEL_ENABLED, 1'b1);
    run_mix(400, 35, 8);
    settle();
    write_register(REG_WHEEL_ENABLED, 1'b0);
    hold_req = 1'b1;
    run_mix(400, 20, 8);

    // Fill the ring past its capacity, then empty it again.
    settle();
    write_register(REG_WHEEL_ENABLED, 1'b1);
    run_mix(320, 0, 0);
    hold_req = 1'b1;
    repeat (80) send_word(ACTION_TAKE, 8'($urandom_range(0, 255)));

    settle();
    write_register(REG_WHEEL_ENABLED, 1'b0);
    run_mix(400, 30, 10);
    settle();
    write_register(REG_WHEEL_ENABLED, 1'b1);
    run_mix(400, 25, 6);

    settle();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("pointer_packet_assembler_fifo_tb: clean");
    end else begin
      $display("pointer_packet_assembler_fifo_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ppa_pkg.sv
design/ppa_ram.sv
design/ppa_framer.sv
design/ppa_ring.sv
design/pointer_packet_assembler_fifo.sv
tb/pointer_packet_assembler_fifo_tb.sv
